// File: rtl/assert_macros.svh
// Assertion helpers for the allocator back engine.
// Both expect i_clk and i_rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define BFA_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Check that a condition in one cycle implies another in the next.
`define BFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bfa_pkg.sv
package bfa_pkg;

    localparam int N_FRAMES    = 65536;
    localparam int FRAME_SHIFT = 12;
    localparam int WORD_BITS   = 32;

    localparam int WORD_COUNT = (N_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W     = $clog2(WORD_COUNT);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int FRAME_W    = $clog2(N_FRAMES);
    localparam int CNT_W      = FRAME_W + 1;

    localparam logic [63:0] LOW_MEM_LIMIT    = 64'h0000_0000_0010_0000;
    localparam logic [31:0] KERNEL_BASE      = 32'h0010_0000;
    localparam logic [31:0] KERNEL_END_RESET = 32'h0010_0000;

    localparam logic [2:0] CMD_REGION  = 3'd0;
    localparam logic [2:0] CMD_RESERVE = 3'd1;
    localparam logic [2:0] CMD_ONE     = 3'd2;
    localparam logic [2:0] CMD_RUN     = 3'd3;
    localparam logic [2:0] CMD_FREE    = 3'd4;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_OOM   = 3'd1,
        ST_BAD   = 3'd2,
        ST_NORUN = 3'd3,
        ST_IGN   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        OP_IGN  = 3'd0,
        OP_CLR  = 3'd1,
        OP_SET  = 3'd2,
        OP_ONE  = 3'd3,
        OP_RUN  = 3'd4,
        OP_FREE = 3'd5
    } t_op;

    // One classified command on its way to the bitmap engine
    typedef struct packed {
        t_op              op;
        t_status          status;
        logic [CNT_W-1:0] lo;
        logic [CNT_W-1:0] hi;
        logic [CNT_W-1:0] n;
    } t_job;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // Index of the lowest set bit; an all-zero argument gives zero
    function automatic logic [BIT_W:0] ctz(input logic [WORD_BITS:0] v);
        logic [BIT_W:0] r;
        r = '0;
        for (int i = WORD_BITS; i >= 0; i--) begin
            if (v[i]) r = (BIT_W+1)'(i);
        end
        return r;
    endfunction

    function automatic logic [BIT_W:0] popcnt(input logic [WORD_BITS-1:0] v);
        logic [BIT_W:0] r;
        r = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            r = r + (BIT_W+1)'(v[i]);
        end
        return r;
    endfunction

endpackage

// File: rtl/bfa_queue.sv
module bfa_queue import bfa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    t_job             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp, r_rp;
    logic [Q_PTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (Q_PTR_W+1)'(i_push) - (Q_PTR_W+1)'(i_pop);
        end
    end

    // Store the word
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

endmodule

// File: rtl/bfa_front.sv
module bfa_front import bfa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_cmd,
    input  logic [63:0] i_region_base,
    input  logic [63:0] i_region_length,
    input  logic        i_region_available,
    input  logic [16:0] i_run_length,
    input  logic [31:0] i_free_address,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_clearing,
    input  logic        i_q_full,
    output logic        o_push,
    output t_job        o_job
);

    localparam int FR_W = 64 - FRAME_SHIFT + 1;
    localparam int KC_W = 33 - FRAME_SHIFT;

    logic        r_a_valid;
    logic [2:0]  r_cmd;
    logic [63:0] r_base, r_len;
    logic        r_avail;
    logic [16:0] r_n;
    logic [31:0] r_faddr;
    logic [31:0] r_kernel_end;

    logic            accept;
    logic [64:0]     end65;
    logic            low, ign;
    logic [63:0]     eb;
    logic [FR_W-1:0] sf_full, ef_full;
    logic [CNT_W-1:0] sf, ef;
    logic [32:0]     ke_sum;
    logic [KC_W-1:0] ke_ceil;
    logic [CNT_W-1:0] k_last;
    logic [31-FRAME_SHIFT:0] ff;

    assign o_stall = i_clearing || (r_a_valid && i_q_full);
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_a_valid && !i_q_full;

    // Hold the accepted word and the kernel end register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid    <= 1'b0;
            r_kernel_end <= KERNEL_END_RESET;
        end else begin
            if (accept)      r_a_valid <= 1'b1;
            else if (o_push) r_a_valid <= 1'b0;
            if (i_cfg_we)    r_kernel_end <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= i_cmd;
            r_base  <= i_region_base;
            r_len   <= i_region_length;
            r_avail <= i_region_available;
            r_n     <= i_run_length;
            r_faddr <= i_free_address;
        end
    end

    // Region range: the end never moves when the low part is cut off
    always_comb begin
        end65   = {1'b0, r_base} + {1'b0, r_len};
        low     = r_base < LOW_MEM_LIMIT;
        ign     = !r_avail || (low && end65 <= {1'b0, LOW_MEM_LIMIT});
        eb      = low ? LOW_MEM_LIMIT : r_base;
        sf_full = FR_W'(eb[63:FRAME_SHIFT]) + FR_W'(|eb[FRAME_SHIFT-1:0]);
        ef_full = end65[64:FRAME_SHIFT];
        sf = (sf_full >= FR_W'(N_FRAMES)) ? CNT_W'(N_FRAMES) : sf_full[CNT_W-1:0];
        ef = (ef_full >= FR_W'(N_FRAMES)) ? CNT_W'(N_FRAMES) : ef_full[CNT_W-1:0];
        ke_sum  = {1'b0, r_kernel_end} + 33'((1 << FRAME_SHIFT) - 1);
        ke_ceil = ke_sum[32:FRAME_SHIFT];
        k_last  = (ke_ceil >= KC_W'(N_FRAMES - 1)) ? CNT_W'(N_FRAMES - 1)
                                                   : ke_ceil[CNT_W-1:0];
        ff      = r_faddr[31:FRAME_SHIFT];
    end

    // Classify the word into a job
    always_comb begin
        o_job.op     = OP_IGN;
        o_job.status = ST_IGN;
        o_job.lo     = '0;
        o_job.hi     = '0;
        o_job.n      = r_n;
        case (r_cmd)
            CMD_REGION: begin
                if (!ign) begin
                    o_job.op     = OP_CLR;
                    o_job.status = ST_OK;
                    o_job.lo     = sf;
                    o_job.hi     = ef;
                end
            end
            CMD_RESERVE: begin
                o_job.op     = OP_SET;
                o_job.status = ST_OK;
                o_job.lo     = CNT_W'(KERNEL_BASE >> FRAME_SHIFT);
                o_job.hi     = k_last + 1'b1;
            end
            CMD_ONE: begin
                o_job.op     = OP_ONE;
                o_job.status = ST_OK;
            end
            CMD_RUN: begin
                if (r_n == '0) begin
                    o_job.status = ST_NORUN;
                end else begin
                    o_job.op     = OP_RUN;
                    o_job.status = ST_OK;
                end
            end
            CMD_FREE: begin
                if (33'(ff) < 33'(N_FRAMES)) begin
                    o_job.op     = OP_FREE;
                    o_job.status = ST_OK;
                    o_job.lo     = CNT_W'(ff);
                end
            end
            default: ;
        endcase
    end

endmodule

// File: rtl/bfa_back.sv
`include "assert_macros.svh"

module bfa_back import bfa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_job        i_job,
    output logic        o_pop,
    output logic        o_clearing,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_frame_address,
    output logic [16:0] o_free_count,
    output logic [16:0] o_total_count
);

    typedef enum logic [10:0] {
        S_CLEAR    = 11'b000_0000_0001,
        S_IDLE     = 11'b000_0000_0010,
        S_RANGE_RD = 11'b000_0000_0100,
        S_RANGE_WR = 11'b000_0000_1000,
        S_ONE_RD   = 11'b000_0001_0000,
        S_ONE_WR   = 11'b000_0010_0000,
        S_RUN_RD   = 11'b000_0100_0000,
        S_RUN_SCAN = 11'b000_1000_0000,
        S_FREE_RD  = 11'b001_0000_0000,
        S_FREE_WR  = 11'b010_0000_0000,
        S_DONE     = 11'b100_0000_0000
    } t_state;

    localparam logic [WORD_BITS-1:0] ONES = '1;

    logic [WORD_BITS-1:0] r_mem [WORD_COUNT];
    logic [WORD_BITS-1:0] r_rdata;

    t_state            r_state, n_state;
    logic [WIDX_W-1:0] r_widx, n_widx;
    logic [CNT_W-1:0]  r_lo, n_lo, r_hi, n_hi, r_n, n_n;
    logic              r_set, n_set;
    t_status           r_status, n_status;
    logic [31:0]       r_addr, n_addr;
    logic [CNT_W-1:0]  r_free, n_free, r_total, n_total;
    logic [FRAME_W-1:0] r_hint, n_hint;
    logic              r_first, n_first;
    logic [WIDX_W:0]   r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_run, n_run;
    logic [FRAME_W-1:0] r_start, n_start;
    logic [BIT_W-1:0]  r_pos, n_pos;

    logic                 r_o_valid;
    t_status              r_o_status;
    logic [31:0]          r_o_addr;
    logic [CNT_W-1:0]     r_o_free, r_o_total;

    logic                 mem_we, mem_re, out_load, out_held;
    logic [WORD_BITS-1:0] mem_wdata;

    // Range helpers
    logic [CNT_W-1:0]     last;
    logic [WORD_BITS-1:0] mask, m_lo, m_hi;
    logic [CNT_W:0]       tsum;
    // Scan helpers
    logic [WORD_BITS-1:0] av, x;
    logic [BIT_W:0]       b1, q, len, endpos;
    logic [WORD_BITS:0]   y;
    logic [CNT_W:0]       newrun;
    logic [FRAME_W-1:0]   cur_start, fidx;

    assign o_clearing = (r_state == S_CLEAR);
    assign out_load   = (r_state == S_DONE) && (!r_o_valid || !i_stall);
    assign out_held   = (r_state == S_DONE) && r_o_valid && i_stall;

    always_comb begin
        last = r_hi - 1'b1;
        m_lo = (r_widx == r_lo[FRAME_W-1:BIT_W]) ? (ONES << r_lo[BIT_W-1:0]) : ONES;
        m_hi = (r_widx == last[FRAME_W-1:BIT_W])
             ? (ONES >> (BIT_W'(WORD_BITS - 1) - last[BIT_W-1:0])) : ONES;
        mask = m_lo & m_hi;
        tsum = (CNT_W+1)'(r_total) + (CNT_W+1)'(popcnt(mask));
        av   = ~r_rdata & (r_first ? (ONES << r_hint[BIT_W-1:0]) : ONES);
        b1   = ctz({1'b0, av});
        fidx = {r_widx, b1[BIT_W-1:0]};
        x    = r_rdata | ~(ONES << r_pos);
        q    = ctz({1'b1, ~x});
        y    = {1'b1, r_rdata} >> r_pos;
        len  = ctz(y);
        endpos = (BIT_W+1)'(r_pos) + len;
        newrun = (CNT_W+1)'(r_run) + (CNT_W+1)'(len);
        cur_start = (r_run == '0) ? {r_widx, r_pos} : r_start;
    end

    // Sequence the bitmap work one word at a time
    always_comb begin
        n_state = r_state;  n_widx = r_widx;  n_lo = r_lo;  n_hi = r_hi;
        n_n = r_n;  n_set = r_set;  n_status = r_status;  n_addr = r_addr;
        n_free = r_free;  n_total = r_total;  n_hint = r_hint;
        n_first = r_first;  n_cnt = r_cnt;  n_run = r_run;
        n_start = r_start;  n_pos = r_pos;
        mem_we = 1'b0;  mem_re = 1'b0;  mem_wdata = r_rdata;  o_pop = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = ONES;
                n_widx    = r_widx + 1'b1;
                if (r_widx == WIDX_W'(WORD_COUNT - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop    = 1'b1;
                    n_lo     = i_job.lo;
                    n_hi     = i_job.hi;
                    n_n      = i_job.n;
                    n_status = i_job.status;
                    n_addr   = '0;
                    n_set    = (i_job.op == OP_SET);
                    n_state  = S_DONE;
                    case (i_job.op)
                        OP_CLR, OP_SET: begin
                            if (i_job.lo < i_job.hi) begin
                                n_widx  = i_job.lo[FRAME_W-1:BIT_W];
                                n_state = S_RANGE_RD;
                            end
                        end
                        OP_ONE: begin
                            if (r_free == '0) begin
                                n_status = ST_OOM;
                            end else begin
                                n_widx  = r_hint[FRAME_W-1:BIT_W];
                                n_first = 1'b1;
                                n_cnt   = '0;
                                n_state = S_ONE_RD;
                            end
                        end
                        OP_RUN: begin
                            n_widx  = '0;
                            n_run   = '0;
                            n_state = S_RUN_RD;
                        end
                        OP_FREE: begin
                            n_widx  = i_job.lo[FRAME_W-1:BIT_W];
                            n_state = S_FREE_RD;
                        end
                        default: ;
                    endcase
                end
            end
            S_RANGE_RD: begin
                mem_re  = 1'b1;
                n_state = S_RANGE_WR;
            end
            S_RANGE_WR: begin
                mem_we = 1'b1;
                if (r_set) begin
                    mem_wdata = r_rdata | mask;
                    n_free    = r_free - CNT_W'(popcnt(mask & ~r_rdata));
                end else begin
                    mem_wdata = r_rdata & ~mask;
                    n_free    = r_free + CNT_W'(popcnt(mask & r_rdata));
                    n_total   = (tsum > (CNT_W+1)'(N_FRAMES)) ? CNT_W'(N_FRAMES)
                                                              : tsum[CNT_W-1:0];
                end
                if (r_widx == last[FRAME_W-1:BIT_W]) begin
                    n_state = S_DONE;
                end else begin
                    n_widx  = r_widx + 1'b1;
                    n_state = S_RANGE_RD;
                end
            end
            S_ONE_RD: begin
                mem_re  = 1'b1;
                n_state = S_ONE_WR;
            end
            S_ONE_WR: begin
                if (av != '0) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_rdata | (ONES & (WORD_BITS'(1) << b1[BIT_W-1:0]));
                    n_free    = r_free - 1'b1;
                    n_hint    = fidx + 1'b1;
                    n_addr    = 32'(fidx) << FRAME_SHIFT;
                    n_state   = S_DONE;
                end else if (r_cnt == (WIDX_W+1)'(WORD_COUNT)) begin
                    n_status = ST_BAD;
                    n_state  = S_DONE;
                end else begin
                    n_widx  = r_widx + 1'b1;
                    n_first = 1'b0;
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_ONE_RD;
                end
            end
            S_RUN_RD: begin
                mem_re  = 1'b1;
                n_pos   = '0;
                n_state = S_RUN_SCAN;
            end
            S_RUN_SCAN: begin
                if (r_rdata[r_pos]) begin
                    // Used bit: drop the run and skip to the next free bit
                    n_run = '0;
                    if (&x) begin
                        if (r_widx == WIDX_W'(WORD_COUNT - 1)) begin
                            n_status = ST_NORUN;
                            n_state  = S_DONE;
                        end else begin
                            n_widx  = r_widx + 1'b1;
                            n_state = S_RUN_RD;
                        end
                    end else begin
                        n_pos = q[BIT_W-1:0];
                    end
                end else if (newrun >= (CNT_W+1)'(r_n)) begin
                    // Run complete: mark it used as a range
                    n_lo    = CNT_W'(cur_start);
                    n_hi    = CNT_W'(cur_start) + r_n;
                    n_set   = 1'b1;
                    n_addr  = 32'(cur_start) << FRAME_SHIFT;
                    n_widx  = cur_start[FRAME_W-1:BIT_W];
                    n_state = S_RANGE_RD;
                end else begin
                    n_run   = newrun[CNT_W-1:0];
                    n_start = cur_start;
                    if (endpos == (BIT_W+1)'(WORD_BITS)) begin
                        if (r_widx == WIDX_W'(WORD_COUNT - 1)) begin
                            n_status = ST_NORUN;
                            n_state  = S_DONE;
                        end else begin
                            n_widx  = r_widx + 1'b1;
                            n_state = S_RUN_RD;
                        end
                    end else begin
                        n_pos = endpos[BIT_W-1:0];
                    end
                end
            end
            S_FREE_RD: begin
                mem_re  = 1'b1;
                n_state = S_FREE_WR;
            end
            S_FREE_WR: begin
                n_state = S_DONE;
                if (r_rdata[r_lo[BIT_W-1:0]]) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_rdata & ~(WORD_BITS'(1) << r_lo[BIT_W-1:0]);
                    n_free    = r_free + 1'b1;
                end else begin
                    n_status = ST_IGN;
                end
            end
            S_DONE: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_widx    <= '0;
            r_free    <= '0;
            r_total   <= '0;
            r_hint    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_widx  <= n_widx;
            r_free  <= n_free;
            r_total <= n_total;
            r_hint  <= n_hint;
            if (out_load)     r_o_valid <= 1'b1;
            else if (!i_stall) r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo <= n_lo;  r_hi <= n_hi;  r_n <= n_n;  r_set <= n_set;
        r_status <= n_status;  r_addr <= n_addr;  r_first <= n_first;
        r_cnt <= n_cnt;  r_run <= n_run;  r_start <= n_start;  r_pos <= n_pos;
        if (out_load) begin
            r_o_status <= r_status;
            r_o_addr   <= r_addr;
            r_o_free   <= r_free;
            r_o_total  <= r_total;
        end
    end

    // Bitmap memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[r_widx] <= mem_wdata;
        if (mem_re) r_rdata <= r_mem[r_widx];
    end

    assign o_valid         = r_o_valid;
    assign o_status        = r_o_status;
    assign o_frame_address = r_o_addr;
    assign o_free_count    = r_o_free;
    assign o_total_count   = r_o_total;

    `BFA_ASSERT(free_in_range, r_free <= CNT_W'(N_FRAMES), "free count exceeds frame count")
    `BFA_ASSERT_NEXT(done_holds, out_held, r_state == S_DONE, "result left while output blocked")
    `BFA_ASSERT_NEXT(total_mono, i_rst_n, r_total >= $past(r_total), "total count decreased")

endmodule

// File: rtl/bitmap_frame_allocator_top.sv
// Bitmap page-frame allocator, one used/free bit per 4 KiB frame.
// Input channel: i_valid/o_stall carries one command word (region, reserve
// kernel, alloc one, alloc run, free); a word is taken when i_valid is high
// and o_stall is low. Output channel: o_valid/i_stall carries one result
// word per command with status, frame address and the free/total counts.
// i_cfg_we/i_cfg_data write the kernel end address into a register.
// A front stage classifies each command into a two-entry job queue; the
// back engine walks the bitmap memory with one read and one write port.
// Ignored and failed-early commands pass the front register, the queue and
// the back engine's idle and done states; region, reserve and alloc one
// read, then write, each bitmap word touched, alloc one scanning from the
// hint; alloc run reads each word and scans its free and used segments,
// then reads and writes each word of the run it marks. One command is
// worked on at a time. After reset a clearing pass marks every frame used;
// o_stall stays high until it is done. When i_stall holds the output, the
// front keeps taking commands until the queue fills, then raises o_stall.
module bitmap_frame_allocator_top import bfa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_cmd,
    input  logic [63:0] i_region_base,
    input  logic [63:0] i_region_length,
    input  logic        i_region_available,
    input  logic [16:0] i_run_length,
    input  logic [31:0] i_free_address,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_frame_address,
    output logic [16:0] o_free_count,
    output logic [16:0] o_total_count
);

    logic clearing, q_full, q_empty, push, pop;
    t_job push_job, pop_job;

    bfa_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_cmd, .i_region_base,
        .i_region_length, .i_region_available, .i_run_length, .i_free_address,
        .i_cfg_we, .i_cfg_data,
        .i_clearing(clearing), .i_q_full(q_full), .o_push(push), .o_job(push_job)
    );

    bfa_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_job(push_job), .o_full(q_full),
        .i_pop(pop), .o_empty(q_empty), .o_job(pop_job)
    );

    bfa_back u_back (
        .i_clk, .i_rst_n, .i_q_empty(q_empty), .i_job(pop_job), .o_pop(pop),
        .o_clearing(clearing), .o_valid, .i_stall, .o_status, .o_frame_address,
        .o_free_count, .o_total_count
    );

endmodule

// File: tb/tb_bitmap_frame_allocator_top.sv
module tb_bitmap_frame_allocator_top import bfa_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LIMIT_CYCLES = 400_000_000;
    localparam logic [2:0]  CMD_SPARE_5  = 3'd5;
    localparam logic [2:0]  CMD_SPARE_6  = 3'd6;
    localparam logic [2:0]  CMD_SPARE_7  = 3'd7;
    localparam logic [63:0] MIB          = 64'h10_0000;

    typedef struct {
        t_status     status;
        logic [31:0] addr;
        logic [16:0] free_cnt;
        logic [16:0] total_cnt;
    } t_frame_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_cmd;
    logic [63:0] i_region_base;
    logic [63:0] i_region_length;
    logic        i_region_available;
    logic [16:0] i_run_length;
    logic [31:0] i_free_address;
    logic        i_cfg_we;
    logic [31:0] i_cfg_data;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_status;
    logic [31:0] o_frame_address;
    logic [16:0] o_free_count;
    logic [16:0] o_total_count;

    bitmap_frame_allocator_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_cmd(i_cmd), .i_region_base(i_region_base), .i_region_length(i_region_length),
        .i_region_available(i_region_available), .i_run_length(i_run_length),
        .i_free_address(i_free_address), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_status(o_status),
        .o_frame_address(o_frame_address), .o_free_count(o_free_count),
        .o_total_count(o_total_count)
    );

    // Shadow allocator state
    bit          frame_used [N_FRAMES];
    int unsigned shadow_free;
    int unsigned shadow_total;
    int unsigned shadow_hint;
    logic [31:0] shadow_kernel_end;

    t_frame_result pending_results[$];
    logic [31:0]   owned_frames[$];

    int  cycle_count;
    int  mismatches;
    int  words_sent;
    int  results_seen;
    int  burst_left;
    int  hold_trigger;
    int  hold_seen;
    int  hold_left;
    int  stall_mode;
    int  ok_allocs;

    // Clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Cycle count and timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("bitmap_frame_allocator_top: mismatch");
            $finish;
        end
    end

    // Receiver stall: long hold when triggered, else a changing pattern
    always @(posedge i_clk) begin
        if (hold_trigger != hold_seen) begin
            hold_seen <= hold_trigger;
            hold_left <= 3000;
            i_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            if (cycle_count % 256 == 0) stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 99) < 20);
                2: i_stall <= ($urandom_range(0, 99) < 60);
                default: i_stall <= cycle_count[0];
            endcase
        end
    end

    // Compare each taken result word against the oldest prediction
    always @(posedge i_clk) begin
        t_frame_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: status %0d addr %h", o_status,
                             o_frame_address);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status || o_frame_address !== want.addr ||
                    o_free_count !== want.free_cnt || o_total_count !== want.total_cnt) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result %0d: want st %0d addr %h free %0d total %0d,",
                                  " got st %0d addr %h free %0d total %0d"},
                                 results_seen, want.status, want.addr, want.free_cnt,
                                 want.total_cnt, o_status, o_frame_address, o_free_count,
                                 o_total_count);
                end
            end
        end
    end

    function automatic t_status apply_region(logic [63:0] base, logic [63:0] len, logic avail);
        logic [64:0] end_sum;
        logic [64:0] end_frame;
        logic [64:0] start_frame;
        logic [63:0] skip;
        if (!avail) return ST_IGN;
        if (base < MIB) begin
            skip = MIB - base;
            if (skip >= len) return ST_IGN;
            base = base + skip;
            len  = len - skip;
        end
        end_sum     = {1'b0, base} + {1'b0, len};
        end_frame   = end_sum >> FRAME_SHIFT;
        start_frame = {1'b0, base >> FRAME_SHIFT} + 65'(base[FRAME_SHIFT-1:0] != 0);
        if (end_frame > 65'(N_FRAMES)) end_frame = 65'(N_FRAMES);
        if (start_frame < end_frame) begin
            for (int f = int'(start_frame); f < int'(end_frame); f++) begin
                if (frame_used[f]) begin
                    frame_used[f] = 1'b0;
                    shadow_free++;
                end
                if (shadow_total < N_FRAMES) shadow_total++;
            end
        end
        return ST_OK;
    endfunction

    function automatic void apply_reserve();
        logic [32:0] last;
        last = ({1'b0, shadow_kernel_end} + 33'd4095) >> FRAME_SHIFT;
        if (last > 33'(N_FRAMES - 1)) last = 33'(N_FRAMES - 1);
        for (int f = int'(KERNEL_BASE >> FRAME_SHIFT); f <= int'(last); f++) begin
            if (!frame_used[f]) begin
                frame_used[f] = 1'b1;
                shadow_free--;
            end
        end
    endfunction

    function automatic t_status take_one(output logic [31:0] addr);
        int f;
        addr = '0;
        if (shadow_free == 0) return ST_OOM;
        for (int i = 0; i < N_FRAMES; i++) begin
            f = (shadow_hint + i) % N_FRAMES;
            if (!frame_used[f]) begin
                frame_used[f] = 1'b1;
                shadow_free--;
                shadow_hint = (f + 1) % N_FRAMES;
                addr = 32'(f << FRAME_SHIFT);
                return ST_OK;
            end
        end
        return ST_BAD;
    endfunction

    function automatic t_status take_run(logic [16:0] n, output logic [31:0] addr);
        int start;
        int run;
        addr  = '0;
        start = 0;
        run   = 0;
        if (n == 0) return ST_NORUN;
        for (int f = 0; f < N_FRAMES; f++) begin
            if (frame_used[f]) begin
                run = 0;
                continue;
            end
            if (run == 0) start = f;
            run++;
            if (run == n) begin
                for (int k = start; k <= f; k++) begin
                    frame_used[k] = 1'b1;
                    shadow_free--;
                end
                addr = 32'(start << FRAME_SHIFT);
                return ST_OK;
            end
        end
        return ST_NORUN;
    endfunction

    function automatic t_status release_frame(logic [31:0] address);
        int f;
        f = int'(address >> FRAME_SHIFT);
        if (f >= N_FRAMES) return ST_IGN;
        if (!frame_used[f]) return ST_IGN;
        frame_used[f] = 1'b0;
        shadow_free++;
        return ST_OK;
    endfunction

    // Predict the result word of one accepted command
    function automatic t_frame_result predict_frame_result();
        t_frame_result r;
        r.addr = '0;
        case (i_cmd)
            CMD_REGION:  r.status = apply_region(i_region_base, i_region_length,
                                                 i_region_available);
            CMD_RESERVE: begin
                apply_reserve();
                r.status = ST_OK;
            end
            CMD_ONE:     r.status = take_one(r.addr);
            CMD_RUN:     r.status = take_run(i_run_length, r.addr);
            CMD_FREE:    r.status = release_frame(i_free_address);
            default:     r.status = ST_IGN;
        endcase
        if (r.status == ST_OK && (i_cmd == CMD_ONE || i_cmd == CMD_RUN)) begin
            owned_frames.push_back(r.addr);
            ok_allocs++;
        end
        r.free_cnt  = shadow_free[16:0];
        r.total_cnt = shadow_total[16:0];
        return r;
    endfunction

    // Offer one command word, hold it until taken, then maybe idle
    task automatic send_word(logic [2:0] cmd, logic [63:0] base = '0, logic [63:0] len = '0,
                             logic avail = 1'b0, logic [16:0] n = '0,
                             logic [31:0] faddr = '0);
        int gap;
        i_valid            <= 1'b1;
        i_cmd              <= cmd;
        i_region_base      <= base;
        i_region_length    <= len;
        i_region_available <= avail;
        i_run_length       <= n;
        i_free_address     <= faddr;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(predict_frame_result());
        words_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 12);
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Write kernel_end while the block is idle
    task automatic write_kernel_end(logic [31:0] value);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        shadow_kernel_end = value;
    endtask

    function automatic logic [31:0] pick_owned();
        int idx;
        logic [31:0] a;
        if (owned_frames.size() == 0) return $urandom();
        idx = $urandom_range(0, owned_frames.size() - 1);
        a = owned_frames[idx];
        owned_frames.delete(idx);
        return a;
    endfunction

    task automatic test_empty_bitmap();
        send_word(CMD_ONE);
        send_word(CMD_RUN, , , , 17'd1);
        send_word(CMD_FREE, , , , , 32'h0000_0000);
        send_word(CMD_FREE, , , , , 32'hFFFF_FFFF);
        send_word(CMD_RESERVE);
        send_word(CMD_SPARE_5);
        send_word(CMD_SPARE_6);
        send_word(CMD_SPARE_7);
    endtask

    task automatic test_region_edges();
        send_word(CMD_REGION, 64'h20_0000, 64'h10_0000, 1'b0);
        send_word(CMD_REGION, 64'h0, MIB, 1'b1);
        send_word(CMD_REGION, 64'h8_0000, 64'h20_0000, 1'b1);
        send_word(CMD_REGION, 64'h30_0123, 64'h5000, 1'b1);
        send_word(CMD_REGION, 64'h20_0000, 64'h0, 1'b1);
        send_word(CMD_REGION, 64'h2_0000_0000, 64'h1000, 1'b1);
        send_word(CMD_REGION, 64'hFFFF_FFFF_FFFF_F000, '1, 1'b1);
        send_word(CMD_REGION, 64'h0FF0_0000, '1, 1'b1);
        send_word(CMD_REGION, 64'h0FF0_0000, '1, 1'b1);
    endtask

    task automatic test_alloc_and_free();
        send_word(CMD_RUN, , , , 17'd0);
        send_word(CMD_RUN, , , , 17'h10000);
        send_word(CMD_RUN, , , , 17'h1FFFF);
        send_word(CMD_RUN, , , , 17'd1);
        send_word(CMD_RUN, , , , 17'd37);
        send_word(CMD_ONE);
        send_word(CMD_ONE);
        send_word(CMD_FREE, , , , , pick_owned());
        send_word(CMD_FREE, , , , , 32'h0010_0000);
        send_word(CMD_FREE, , , , , 32'h0010_0000);
        send_word(CMD_FREE, , , , , 32'h0FFF_F000);
    endtask

    // Kernel end at both extremes, reserve, then give memory back
    task automatic test_kernel_end_extremes();
        write_kernel_end(32'h0000_0000);
        send_word(CMD_RESERVE);
        write_kernel_end(32'hFFFF_FFFF);
        send_word(CMD_RESERVE);
        send_word(CMD_ONE);
        send_word(CMD_REGION, 64'h0, 64'h1000_0000, 1'b1);
        write_kernel_end(32'h0010_0001);
        send_word(CMD_RESERVE);
    endtask

    task automatic send_random_word();
        int pick;
        logic [63:0] base;
        pick = $urandom_range(0, 99);
        base = MIB + 64'($urandom_range(0, 32'h0FEF_FFFF));
        if (pick < 25)      send_word(CMD_ONE);
        else if (pick < 45) send_word(CMD_FREE, , , , , pick_owned());
        else if (pick < 53) send_word(CMD_FREE, , , , , $urandom());
        else if (pick < 68) send_word(CMD_RUN, , , , 17'($urandom_range(1, 16)));
        else if (pick < 71) send_word(CMD_RUN, , , , 17'($urandom()));
        else if (pick < 83) send_word(CMD_REGION, base, 64'($urandom_range(0, 32'h4_0000)),
                                      1'b1);
        else if (pick < 87) send_word(CMD_REGION, {$urandom(), $urandom()},
                                      {$urandom(), $urandom()}, 1'b1);
        else if (pick < 90) send_word(CMD_REGION, {$urandom(), $urandom()},
                                      {$urandom(), $urandom()}, 1'b0);
        else if (pick < 93) send_word(CMD_RESERVE);
        else send_word(3'(CMD_FREE + $urandom_range(1, 3)), {$urandom(), $urandom()},
                       {$urandom(), $urandom()}, 1'($urandom()), 17'($urandom()),
                       $urandom());
    endtask

    task automatic test_random_mix(int count);
        repeat (count) send_random_word();
    endtask

    // Hold the output long enough for the queue to fill and stall the input
    task automatic test_output_hold();
        drain_results();
        hold_trigger++;
        burst_left = 30;
        repeat (20) send_word(CMD_ONE);
    endtask

    // Stop sending until every result is back, then resume
    task automatic test_sender_pause();
        repeat (6) send_word(CMD_RUN, , , , 17'($urandom_range(1, 4)));
        drain_results();
        repeat (6) send_word(CMD_FREE, , , , , pick_owned());
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        i_valid            <= 1'b0;
        i_cmd              <= CMD_REGION;
        i_region_base      <= '0;
        i_region_length    <= '0;
        i_region_available <= 1'b0;
        i_run_length       <= '0;
        i_free_address     <= '0;
        i_cfg_we           <= 1'b0;
        i_cfg_data         <= '0;
        i_stall            <= 1'b0;
        cycle_count  = 0;
        mismatches   = 0;
        words_sent   = 0;
        results_seen = 0;
        burst_left   = 0;
        hold_trigger = 0;
        hold_seen    = 0;
        hold_left    = 0;
        stall_mode   = 0;
        ok_allocs    = 0;
        foreach (frame_used[f]) frame_used[f] = 1'b1;
        shadow_free       = 0;
        shadow_total      = 0;
        shadow_hint       = 0;
        shadow_kernel_end = KERNEL_END_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_bitmap();
        test_region_edges();
        test_alloc_and_free();
        test_kernel_end_extremes();
        test_output_hold();
        test_sender_pause();
        test_random_mix(350);
        write_kernel_end(32'h0010_0000 + $urandom_range(0, 32'h30_0000));
        test_random_mix(350);
        write_kernel_end(32'h00FF_F001);
        test_random_mix(350);
        write_kernel_end($urandom_range(0, 32'h40_0000));
        test_random_mix(350);
        drain_results();

        $display("Sent %0d command words, checked %0d result words, %0d allocations succeeded.",
                 words_sent, results_seen, ok_allocs);
        $display("Covered region edge cases, kernel reserve at both limits, runs, frees, stalls.");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("bitmap_frame_allocator_top: match");
        end else begin
            $display("bitmap_frame_allocator_top: mismatch");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/bfa_pkg.sv
rtl/bfa_queue.sv
rtl/bfa_front.sv
rtl/bfa_back.sv
rtl/bitmap_frame_allocator_top.sv
tb/tb_bitmap_frame_allocator_top.sv
